// ===== hw/rtl/sea_pkg.sv =====
`default_nettype none
package sea_pkg;

	localparam int ADDR_W        = 24;
	localparam int ID_W          = 31;
	localparam int EXT_DEPTH     = 1024;
	localparam int EXT_AW        = 10;
	localparam int CNT_W         = 11;
	localparam int MAX_FILES     = 256;
	localparam int FILE_AW       = 8;
	localparam int SCAN_W        = 9;
	localparam int MAX_FRAGMENTS = 64;
	localparam int FRAG_AW       = 6;
	localparam int K_W           = 7;
	localparam int EXT_W         = 2 * ADDR_W;

	localparam logic [1:0] STATUS_DONE    = 2'd0;
	localparam logic [1:0] STATUS_NOSPACE = 2'd1;
	localparam logic [1:0] STATUS_FULL    = 2'd2;

	localparam logic OP_ALLOC  = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef struct packed {
		logic init;
		logic load_req;
		logic scan_start;
		logic scan_step;
		logic decide;
		logic cnt_rd;
		logic cnt_ev;
		logic commit_hdr;
		logic com_rd;
		logic com_ev;
		logic com_end;
		logic n_load;
		logic fr_rd;
		logic pos_rd;
		logic pos_adv;
		logic sh_init;
		logic sh_rd;
		logic sh_wr;
		logic ins;
		logic rm_end;
		logic res_nospace;
		logic res_full;
		logic res_zero;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic op_remove;
		logic too_big;
		logic scan_done;
		logic match;
		logic slot_ok;
		logic need_zero;
		logic k_eq_cnt;
		logic k_eq_max;
		logic idx_eq_k;
		logic n_ovf;
		logic idx_eq_n;
		logic pos_eq_cnt;
		logic ext_lt;
		logic j_eq_pos;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sea_ctrl.sv =====
`default_nettype none
module sea_ctrl import sea_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic cfg_we,
	input  wire sts_t sts,
	output logic      in_ready,
	output cmd_t      cmd
);

	typedef enum logic [20:0] {
		S_INIT    = 21'h000001,
		S_IDLE    = 21'h000002,
		S_CHECK   = 21'h000004,
		S_SCAN    = 21'h000008,
		S_DECIDE  = 21'h000010,
		S_CNT_RD  = 21'h000020,
		S_CNT_EV  = 21'h000040,
		S_COMMIT  = 21'h000080,
		S_COM_RD  = 21'h000100,
		S_COM_EV  = 21'h000200,
		S_COM_END = 21'h000400,
		S_N_WAIT  = 21'h000800,
		S_FR_RD   = 21'h001000,
		S_POS_RD  = 21'h002000,
		S_POS_EV  = 21'h004000,
		S_SH_INIT = 21'h008000,
		S_SH_RD   = 21'h010000,
		S_SH_WR   = 21'h020000,
		S_INS     = 21'h040000,
		S_RM_END  = 21'h080000,
		S_DONE    = 21'h100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_INIT: begin
				cmd.init = 1'b1;
				state_d  = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_CHECK;
				end else if (cfg_we) begin
					state_d = S_INIT;
				end
			end
			S_CHECK: begin
				if (!sts.op_remove && sts.too_big) begin
					cmd.res_nospace = 1'b1;
					state_d         = S_DONE;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				if (sts.op_remove) begin
					if (!sts.match) begin
						cmd.res_zero = 1'b1;
						state_d      = S_DONE;
					end else begin
						state_d = S_N_WAIT;
					end
				end else if (!sts.slot_ok) begin
					cmd.res_full = 1'b1;
					state_d      = S_DONE;
				end else begin
					state_d = S_CNT_RD;
				end
			end
			S_CNT_RD: begin
				if (sts.need_zero || sts.k_eq_cnt) begin
					state_d = S_COMMIT;
				end else if (sts.k_eq_max) begin
					cmd.res_full = 1'b1;
					state_d      = S_DONE;
				end else begin
					cmd.cnt_rd = 1'b1;
					state_d    = S_CNT_EV;
				end
			end
			S_CNT_EV: begin
				cmd.cnt_ev = 1'b1;
				state_d    = S_CNT_RD;
			end
			S_COMMIT: begin
				cmd.commit_hdr = 1'b1;
				state_d        = S_COM_RD;
			end
			S_COM_RD: begin
				if (sts.idx_eq_k) begin
					state_d = S_COM_END;
				end else begin
					cmd.com_rd = 1'b1;
					state_d    = S_COM_EV;
				end
			end
			S_COM_EV: begin
				cmd.com_ev = 1'b1;
				state_d    = S_COM_RD;
			end
			S_COM_END: begin
				cmd.com_end = 1'b1;
				state_d     = S_DONE;
			end
			S_N_WAIT: begin
				if (sts.n_ovf) begin
					cmd.res_full = 1'b1;
					state_d      = S_DONE;
				end else begin
					cmd.n_load = 1'b1;
					state_d    = S_FR_RD;
				end
			end
			S_FR_RD: begin
				if (sts.idx_eq_n) begin
					state_d = S_RM_END;
				end else begin
					cmd.fr_rd = 1'b1;
					state_d   = S_POS_RD;
				end
			end
			S_POS_RD: begin
				if (sts.pos_eq_cnt) begin
					state_d = S_SH_INIT;
				end else begin
					cmd.pos_rd = 1'b1;
					state_d    = S_POS_EV;
				end
			end
			S_POS_EV: begin
				if (sts.ext_lt) begin
					cmd.pos_adv = 1'b1;
					state_d     = S_POS_RD;
				end else begin
					state_d = S_SH_INIT;
				end
			end
			S_SH_INIT: begin
				cmd.sh_init = 1'b1;
				state_d     = S_SH_RD;
			end
			S_SH_RD: begin
				if (sts.j_eq_pos) begin
					state_d = S_INS;
				end else begin
					cmd.sh_rd = 1'b1;
					state_d   = S_SH_WR;
				end
			end
			S_SH_WR: begin
				cmd.sh_wr = 1'b1;
				state_d   = S_SH_RD;
			end
			S_INS: begin
				cmd.ins = 1'b1;
				state_d = S_FR_RD;
			end
			S_RM_END: begin
				cmd.rm_end = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== hw/rtl/sea_datapath.sv =====
`default_nettype none
module sea_datapath import sea_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	input  wire logic              cfg_we,
	input  wire logic [ADDR_W-1:0] cfg_wdata,
	input  wire logic              in_op,
	input  wire logic [ID_W-1:0]   in_id,
	input  wire logic [ADDR_W-1:0] in_size,
	input  wire logic              out_ready,
	output logic                   out_valid,
	output logic [1:0]             out_status,
	output logic [ADDR_W-1:0]      out_start,
	output logic [K_W-1:0]         out_fc,
	output sts_t                   sts
);

	logic [EXT_W-1:0]  ext_mem [EXT_DEPTH];
	logic [ID_W-1:0]   tag_mem [MAX_FILES];
	logic [K_W-1:0]    fc_mem  [MAX_FILES];
	logic [EXT_W-1:0]  frag_mem [MAX_FILES * MAX_FRAGMENTS];

	logic [EXT_W-1:0]  ext_rd_q, frag_rd_q;
	logic [ID_W-1:0]   tag_rd_q;
	logic [K_W-1:0]    fc_rd_q;

	logic [ADDR_W-1:0] cap_q, funits_q;
	logic [EXT_AW-1:0] head_q;
	logic [CNT_W-1:0]  cnt_q, pos_q, j_q;
	logic [MAX_FILES-1:0] fvalid_q;

	logic              op_q;
	logic [ID_W-1:0]   id_q;
	logic [ADDR_W-1:0] size_q, need_q, start0_q;

	logic [SCAN_W-1:0]  scan_i_q;
	logic               scan_v_s1;
	logic [FILE_AW-1:0] idx_s1;
	logic               match_q, free_found_q;
	logic [FILE_AW-1:0] mslot_q, fslot_q, slot_q;

	logic [K_W-1:0]    k_q, idx_q, n_q, full_q;

	logic [1:0]        res_status_q;
	logic [ADDR_W-1:0] res_start_q;
	logic [K_W-1:0]    res_fc_q;

	logic [ADDR_W-1:0] ext_s, ext_e, ext_len, frag_s, frag_e;
	logic              fits;
	logic              ext_we, ext_re;
	logic [CNT_W-1:0]  ext_wl, ext_rl;
	logic [EXT_W-1:0]  ext_wd;
	logic              hit;

	assign ext_s   = ext_rd_q[ADDR_W-1:0];
	assign ext_e   = ext_rd_q[EXT_W-1:ADDR_W];
	assign ext_len = ext_e - ext_s + ADDR_W'(1);
	assign fits    = (ext_len <= need_q);
	assign frag_s  = frag_rd_q[ADDR_W-1:0];
	assign frag_e  = frag_rd_q[EXT_W-1:ADDR_W];
	assign hit     = scan_v_s1 && fvalid_q[idx_s1] && (tag_rd_q == id_q);

	always_comb begin
		ext_we = 1'b0;
		ext_wl = '0;
		ext_wd = '0;
		if (cmd.init) begin
			ext_we = 1'b1;
			ext_wd = {cap_q, ADDR_W'(1)};
		end else if (cmd.com_ev && !fits) begin
			ext_we = 1'b1;
			ext_wl = CNT_W'(idx_q);
			ext_wd = {ext_e, ext_s + need_q};
		end else if (cmd.sh_wr) begin
			ext_we = 1'b1;
			ext_wl = j_q;
			ext_wd = ext_rd_q;
		end else if (cmd.ins) begin
			ext_we = 1'b1;
			ext_wl = pos_q;
			ext_wd = frag_rd_q;
		end
	end

	always_comb begin
		ext_re = cmd.cnt_rd || cmd.com_rd || cmd.pos_rd || cmd.sh_rd;
		ext_rl = '0;
		if (cmd.cnt_rd) ext_rl = CNT_W'(k_q);
		else if (cmd.com_rd) ext_rl = CNT_W'(idx_q);
		else if (cmd.pos_rd) ext_rl = pos_q;
		else if (cmd.sh_rd) ext_rl = j_q - CNT_W'(1);
	end

	always_ff @(posedge clk) begin
		if (ext_we) ext_mem[cmd.init ? '0 : head_q + ext_wl[EXT_AW-1:0]] <= ext_wd;
		if (ext_re) ext_rd_q <= ext_mem[head_q + ext_rl[EXT_AW-1:0]];
		if (cmd.commit_hdr) begin
			tag_mem[slot_q] <= id_q;
			fc_mem[slot_q]  <= k_q;
		end
		if (cmd.scan_step && !scan_i_q[SCAN_W-1]) tag_rd_q <= tag_mem[scan_i_q[FILE_AW-1:0]];
		if (cmd.decide) fc_rd_q <= fc_mem[mslot_q];
		if (cmd.com_ev) begin
			frag_mem[{slot_q, idx_q[FRAG_AW-1:0]}] <=
				{fits ? ext_e : ext_s + need_q - ADDR_W'(1), ext_s};
		end
		if (cmd.fr_rd) frag_rd_q <= frag_mem[{slot_q, idx_q[FRAG_AW-1:0]}];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q   <= in_op;
			id_q   <= in_id;
			size_q <= in_size;
		end
		if (cmd.decide) begin
			slot_q <= match_q ? mslot_q : fslot_q;
			need_q <= size_q;
			k_q    <= '0;
		end
		if (cmd.cnt_ev) begin
			need_q <= fits ? need_q - ext_len : '0;
			k_q    <= k_q + K_W'(1);
		end
		if (cmd.commit_hdr) begin
			idx_q    <= '0;
			need_q   <= size_q;
			full_q   <= '0;
			start0_q <= '0;
		end
		if (cmd.com_ev) begin
			if (idx_q == '0) start0_q <= ext_s;
			if (fits) begin
				need_q <= need_q - ext_len;
				full_q <= full_q + K_W'(1);
			end else begin
				need_q <= '0;
			end
			idx_q <= idx_q + K_W'(1);
		end
		if (cmd.n_load) begin
			n_q   <= fc_rd_q;
			idx_q <= '0;
		end
		if (cmd.fr_rd) pos_q <= '0;
		if (cmd.pos_adv) pos_q <= pos_q + CNT_W'(1);
		if (cmd.sh_init) j_q <= cnt_q;
		if (cmd.sh_wr) j_q <= j_q - CNT_W'(1);
		if (cmd.ins) idx_q <= idx_q + K_W'(1);
		if (cmd.scan_start) begin
			match_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else if (scan_v_s1) begin
			if (hit) begin
				match_q <= 1'b1;
				mslot_q <= idx_s1;
			end
			if (!free_found_q && !fvalid_q[idx_s1]) begin
				free_found_q <= 1'b1;
				fslot_q      <= idx_s1;
			end
		end
		if (cmd.scan_step) idx_s1 <= scan_i_q[FILE_AW-1:0];
		if (cmd.res_nospace) begin
			res_status_q <= STATUS_NOSPACE;
			res_start_q  <= '0;
			res_fc_q     <= '0;
		end
		if (cmd.res_full) begin
			res_status_q <= STATUS_FULL;
			res_start_q  <= '0;
			res_fc_q     <= '0;
		end
		if (cmd.res_zero) begin
			res_status_q <= STATUS_DONE;
			res_start_q  <= '0;
			res_fc_q     <= '0;
		end
		if (cmd.com_end) begin
			res_status_q <= STATUS_DONE;
			res_start_q  <= start0_q;
			res_fc_q     <= k_q;
		end
		if (cmd.rm_end) begin
			res_status_q <= STATUS_DONE;
			res_start_q  <= '0;
			res_fc_q     <= n_q;
		end
		if (cmd.out_load) begin
			out_status <= res_status_q;
			out_start  <= res_start_q;
			out_fc     <= res_fc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= '1;
			funits_q  <= '0;
			head_q    <= '0;
			cnt_q     <= '0;
			fvalid_q  <= '0;
			scan_i_q  <= '0;
			scan_v_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;
			if (cmd.init) begin
				funits_q <= cap_q;
				head_q   <= '0;
				cnt_q    <= (cap_q != '0) ? CNT_W'(1) : '0;
				fvalid_q <= '0;
			end
			if (cmd.com_end) begin
				head_q   <= head_q + EXT_AW'(full_q);
				cnt_q    <= cnt_q - CNT_W'(full_q);
				funits_q <= funits_q - size_q;
			end
			if (cmd.commit_hdr) fvalid_q[slot_q] <= 1'b1;
			if (cmd.ins) begin
				cnt_q    <= cnt_q + CNT_W'(1);
				funits_q <= funits_q + (frag_e - frag_s + ADDR_W'(1));
			end
			if (cmd.rm_end) fvalid_q[slot_q] <= 1'b0;
			if (cmd.scan_start) begin
				scan_i_q  <= '0;
				scan_v_s1 <= 1'b0;
			end else if (cmd.scan_step) begin
				scan_v_s1 <= !scan_i_q[SCAN_W-1];
				if (!scan_i_q[SCAN_W-1]) scan_i_q <= scan_i_q + SCAN_W'(1);
			end
			if (cmd.out_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_comb begin
		sts.op_remove  = (op_q == OP_REMOVE);
		sts.too_big    = (size_q > funits_q);
		sts.scan_done  = scan_v_s1 && (idx_s1 == FILE_AW'(MAX_FILES - 1));
		sts.match      = match_q;
		sts.slot_ok    = match_q || free_found_q;
		sts.need_zero  = (need_q == '0);
		sts.k_eq_cnt   = (CNT_W'(k_q) == cnt_q);
		sts.k_eq_max   = (k_q == K_W'(MAX_FRAGMENTS));
		sts.idx_eq_k   = (idx_q == k_q);
		sts.n_ovf      = ((CNT_W + 1)'(cnt_q) + (CNT_W + 1)'(fc_rd_q)) >
			(CNT_W + 1)'(EXT_DEPTH);
		sts.idx_eq_n   = (idx_q == n_q);
		sts.pos_eq_cnt = (pos_q == cnt_q);
		sts.ext_lt     = (ext_s < frag_s);
		sts.j_eq_pos   = (j_q == pos_q);
		sts.out_free   = !out_valid || out_ready;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/scatter_extent_allocator.sv =====
// Address-ordered first-fit extent allocator over units 1 to capacity.
// Request words enter on s_axis (tuser: 0 allocate, 1 remove; tdata: file id,
// size). Each word gives one response word on m_axis: status, lowest start
// address, fragment count.
// One request is worked on at a time. Every request but an allocate refused for
// lack of space scans the 256-entry file table, one entry a cycle. An allocate
// then walks the free extent memory twice (up to 64 extents used). A remove
// takes each fragment back by a sorted insert into the free extent memory: it
// reads past each entry that starts below the fragment to find the place, then
// moves each later entry up by one and writes the fragment in.
// cfg_we writes capacity; the user must assert it only while the block is idle,
// which the block itself does not enforce. In idle with no request waiting, the
// block then rebuilds the free space and drops all files in its init state.
// After reset the same rebuild runs with capacity 16777215.
// A response waits in the output register while m_tready is low; a new request
// may be accepted meanwhile, but its response is held until the old one leaves.
`default_nettype none
module scatter_extent_allocator import sea_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [23:0] cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,  // file_id[30:0], alloc_size[54:31], pad
	input  wire logic        s_tuser,  // op
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata   // status[1:0], start_addr[25:2], fragment_count[32:26]
);

	cmd_t              cmd;
	sts_t              sts;
	logic [1:0]        status;
	logic [ADDR_W-1:0] start_addr;
	logic [K_W-1:0]    fragment_count;

	sea_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.cfg_we   (cfg_we),
		.sts      (sts),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	sea_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_op      (s_tuser),
		.in_id      (s_tdata[30:0]),
		.in_size    (s_tdata[54:31]),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_status (status),
		.out_start  (start_addr),
		.out_fc     (fragment_count),
		.sts        (sts)
	);

	assign m_tdata = {7'd0, fragment_count, start_addr, status};

endmodule
`default_nettype wire
